### design/fdr_pkg.sv
`default_nettype none

package fdr_pkg;

   // Square root: one radicand bit pair per step, two steps per stage.
   localparam int RAD_W       = 62;
   localparam int ROOT_W      = 31;
   localparam int SQRT_STAGES = (RAD_W / 2 + 1) / 2;

   // Ratio divider: Q1.31 quotient of a 32-bit difference by a 32-bit sum.
   localparam int QUO_W      = 32;
   localparam int DIV_STAGES = QUO_W / 2;

   typedef logic [RAD_W-1:0]  fdr_rad_type;
   typedef logic [ROOT_W-1:0] fdr_root_type;
   typedef logic [QUO_W-1:0]  fdr_quo_type;

endpackage

`default_nettype wire

### design/fdr_sqrt.sv
`default_nettype none

module fdr_sqrt (
   input  logic                 clock,
   input  logic                 advance,
   input  fdr_pkg::fdr_rad_type  radicand,
   output fdr_pkg::fdr_root_type root
);
   import fdr_pkg::*;

   typedef struct packed {
      logic [RAD_W-1:0] rem;
      logic [RAD_W:0]   res;
   } sqrt_state_type;

   localparam logic [RAD_W+1:0] TRIAL_ONE = 1;
   localparam logic [RAD_W:0]   RES_ONE   = 1;

   function automatic sqrt_state_type sqrt_step(input sqrt_state_type st, input int k);
      logic [RAD_W+1:0] trial;
      sqrt_state_type   nx;
      trial = {1'b0, st.res} + (TRIAL_ONE << (2 * k));
      if ({2'b00, st.rem} >= trial) begin
         nx.rem = RAD_W'({2'b00, st.rem} - trial);
         nx.res = (st.res >> 1) + (RES_ONE << (2 * k));
      end else begin
         nx.rem = st.rem;
         nx.res = st.res >> 1;
      end
      return nx;
   endfunction

   sqrt_state_type stage_ff [SQRT_STAGES];
   sqrt_state_type stage_in [SQRT_STAGES];

   always_comb begin
      sqrt_state_type prev;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            prev.rem = radicand;
            prev.res = '0;
         end else begin
            prev = stage_ff[j-1];
         end
         stage_in[j] = sqrt_step(sqrt_step(prev, 2 * SQRT_STAGES - 1 - 2 * j),
                                 2 * SQRT_STAGES - 2 - 2 * j);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < SQRT_STAGES; j++) begin
            stage_ff[j] <= stage_in[j];
         end
      end
   end

   assign root = stage_ff[SQRT_STAGES-1].res[ROOT_W-1:0];

endmodule

`default_nettype wire

### design/fdr_divider.sv
`default_nettype none

module fdr_divider (
   input  logic                clock,
   input  logic                advance,
   input  fdr_pkg::fdr_quo_type dividend,
   input  fdr_pkg::fdr_quo_type divisor,
   output fdr_pkg::fdr_quo_type quotient
);
   import fdr_pkg::*;

   typedef struct packed {
      logic [QUO_W-1:0] rem;
      logic [QUO_W-1:0] dvs;
      logic [QUO_W-1:0] quo;
   } div_state_type;

   // First step takes the integer bit without a shift.
   function automatic div_state_type div_step(input div_state_type st, input logic first);
      logic [QUO_W:0] trial;
      div_state_type  nx;
      trial  = first ? {1'b0, st.rem} : {st.rem, 1'b0};
      nx.dvs = st.dvs;
      if (trial >= {1'b0, st.dvs}) begin
         nx.rem = QUO_W'(trial - {1'b0, st.dvs});
         nx.quo = {st.quo[QUO_W-2:0], 1'b1};
      end else begin
         nx.rem = trial[QUO_W-1:0];
         nx.quo = {st.quo[QUO_W-2:0], 1'b0};
      end
      return nx;
   endfunction

   div_state_type stage_ff [DIV_STAGES];
   div_state_type stage_in [DIV_STAGES];

   always_comb begin
      div_state_type prev;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            prev.rem = dividend;
            prev.dvs = divisor;
            prev.quo = '0;
         end else begin
            prev = stage_ff[j-1];
         end
         stage_in[j] = div_step(div_step(prev, j == 0), 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < DIV_STAGES; j++) begin
            stage_ff[j] <= stage_in[j];
         end
      end
   end

   assign quotient = stage_ff[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

### design/fresnel_dielectric_reflectance.sv
// Pipeline: 5 setup stages, 16 root stages, 4 ratio setup stages, 16 divider
// stages, then the square and sum stages.
// Throughput: one item per cycle; the 16-stage root and the 16-stage dividers
// each retire two result bits per stage. A stalled result holds the whole pipe.
// Reset (synchronous, active high) clears every valid bit and loads the index
// registers with 4096 (outside) and 6144 (inside).
`default_nettype none

module fresnel_dielectric_reflectance #(
   parameter int COS_FRAC_BITS = 15
) (
   input  logic               clock,
   input  logic               reset,
   // item input
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_cos_incident,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_reflectance,
   output logic               rsp_total_internal,
   output logic               rsp_is_entering,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import fdr_pkg::*;

   localparam logic REG_OUTSIDE = 1'b0;
   localparam logic REG_INSIDE  = 1'b1;

   // Clamp bound and the scaling of sin^2 = 1 - cos^2 and of cos into Q0.30.
   localparam logic signed [31:0] COS_ONE = 32'sd1 <<< COS_FRAC_BITS;
   localparam logic [61:0]        ONE_SQ  = 62'd1 << (2 * COS_FRAC_BITS);
   localparam int S2_DN = (2 * COS_FRAC_BITS >= 30) ? 2 * COS_FRAC_BITS - 30 : 0;
   localparam int S2_UP = (2 * COS_FRAC_BITS < 30) ? 30 - 2 * COS_FRAC_BITS : 0;
   localparam int A_SH  = 30 - COS_FRAC_BITS;

   // Right shift that brings a ratio sum below 2^32.
   function automatic logic [4:0] norm_shift(input logic [62:0] s);
      logic [4:0] sh;
      sh = '0;
      for (int i = 32; i < 63; i++) begin
         if (s[i]) begin
            sh = 5'(i - 31);
         end
      end
      return sh;
   endfunction

   //------------------------------------------------------------------
   // Register port
   //------------------------------------------------------------------
   logic [15:0] index_outside_ff;
   logic [15:0] index_inside_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_outside_ff <= 16'd4096;
         index_inside_ff  <= 16'd6144;
      end else if (csr_write) begin
         case (paddr[2])
            REG_OUTSIDE: index_outside_ff <= pwdata[15:0];
            REG_INSIDE:  index_inside_ff  <= pwdata[15:0];
            default:     index_outside_ff <= index_outside_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_OUTSIDE: prdata = {16'd0, index_outside_ff};
         REG_INSIDE:  prdata = {16'd0, index_inside_ff};
         default:     prdata = '0;
      endcase
   end

   //------------------------------------------------------------------
   // Pipeline control: every stage advances together unless the result
   // register holds an item nobody takes.
   //------------------------------------------------------------------
   logic pipe_advance;
   logic rsp_valid_ff;

   assign pipe_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready    = pipe_advance;
   assign rsp_valid    = rsp_valid_ff;

   logic p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic p6_v_ff, p7_v_ff, p8_v_ff, p9_v_ff, p10_v_ff;
   logic sq_v_ff [SQRT_STAGES];
   logic dv_v_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         p3_v_ff      <= 1'b0;
         p4_v_ff      <= 1'b0;
         p5_v_ff      <= 1'b0;
         p6_v_ff      <= 1'b0;
         p7_v_ff      <= 1'b0;
         p8_v_ff      <= 1'b0;
         p9_v_ff      <= 1'b0;
         p10_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SQRT_STAGES; i++) begin
            sq_v_ff[i] <= 1'b0;
         end
         for (int i = 0; i < DIV_STAGES; i++) begin
            dv_v_ff[i] <= 1'b0;
         end
      end else if (pipe_advance) begin
         p1_v_ff    <= req_valid;
         p2_v_ff    <= p1_v_ff;
         p3_v_ff    <= p2_v_ff;
         p4_v_ff    <= p3_v_ff;
         p5_v_ff    <= p4_v_ff;
         sq_v_ff[0] <= p5_v_ff;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            sq_v_ff[i] <= sq_v_ff[i-1];
         end
         p6_v_ff    <= sq_v_ff[SQRT_STAGES-1];
         p7_v_ff    <= p6_v_ff;
         p8_v_ff    <= p7_v_ff;
         p9_v_ff    <= p8_v_ff;
         dv_v_ff[0] <= p9_v_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            dv_v_ff[i] <= dv_v_ff[i-1];
         end
         p10_v_ff     <= dv_v_ff[DIV_STAGES-1];
         rsp_valid_ff <= p10_v_ff;
      end
   end

   //------------------------------------------------------------------
   // Stage 1: clamp the cosine, take its magnitude, pick the indices.
   // A cosine that is not positive leaves the medium: swap the indices.
   //------------------------------------------------------------------
   logic signed [31:0] cos_ext;
   logic signed [31:0] cos_clamp;
   logic signed [31:0] cos_abs;
   logic [15:0]        p1_a_in;
   logic               p1_ent_in;
   logic [15:0]        p1_a_ff, p1_ei_ff, p1_et_ff;
   logic               p1_ent_ff;

   always_comb begin
      cos_ext = 32'(req_cos_incident);
      if (cos_ext > COS_ONE) begin
         cos_clamp = COS_ONE;
      end else if (cos_ext < -COS_ONE) begin
         cos_clamp = -COS_ONE;
      end else begin
         cos_clamp = cos_ext;
      end
      cos_abs   = (cos_clamp < 0) ? -cos_clamp : cos_clamp;
      p1_a_in   = cos_abs[15:0];
      p1_ent_in = cos_ext > 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p1_a_ff   <= p1_a_in;
         p1_ent_ff <= p1_ent_in;
         p1_ei_ff  <= p1_ent_in ? index_outside_ff : index_inside_ff;
         p1_et_ff  <= p1_ent_in ? index_inside_ff : index_outside_ff;
      end
   end

   //------------------------------------------------------------------
   // Stage 2: square cosine and both indices; cosine into Q0.30.
   //------------------------------------------------------------------
   logic [30:0] p2_a2_ff, p2_A_ff;
   logic [31:0] p2_ei2_ff, p2_et2_ff;
   logic [15:0] p2_ei_ff;
   logic        p2_ent_ff;

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p2_a2_ff  <= 31'(32'(p1_a_ff) * 32'(p1_a_ff));
         p2_A_ff   <= {15'd0, p1_a_ff} << A_SH;
         p2_ei2_ff <= 32'(p1_ei_ff) * 32'(p1_ei_ff);
         p2_et2_ff <= 32'(p1_et_ff) * 32'(p1_et_ff);
         p2_ei_ff  <= p1_ei_ff;
         p2_ent_ff <= p1_ent_ff;
      end
   end

   //------------------------------------------------------------------
   // Stage 3: sin^2 = 1 - cos^2 in Q0.30 (truncating).
   //------------------------------------------------------------------
   logic [61:0] s2_diff;
   logic [30:0] p3_s2_in;
   logic [30:0] p3_s2_ff, p3_A_ff;
   logic [31:0] p3_ei2_ff, p3_et2_ff;
   logic [15:0] p3_ei_ff;
   logic        p3_ent_ff;

   assign s2_diff  = ONE_SQ - {31'd0, p2_a2_ff};
   assign p3_s2_in = 31'((s2_diff >> S2_DN) << S2_UP);

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p3_s2_ff  <= p3_s2_in;
         p3_A_ff   <= p2_A_ff;
         p3_ei2_ff <= p2_ei2_ff;
         p3_et2_ff <= p2_et2_ff;
         p3_ei_ff  <= p2_ei_ff;
         p3_ent_ff <= p2_ent_ff;
      end
   end

   //------------------------------------------------------------------
   // Stage 4: Snell's law in squared form, ei^2*sin^2 against et^2.
   //------------------------------------------------------------------
   logic [62:0] p4_lhs_ff;
   logic [61:0] p4_rhs_ff;
   logic [30:0] p4_A_ff;
   logic [31:0] p4_et2_ff;
   logic [15:0] p4_ei_ff;
   logic        p4_ent_ff;

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p4_lhs_ff <= 63'(p3_ei2_ff) * 63'(p3_s2_ff);
         p4_rhs_ff <= {p3_et2_ff, 30'd0};
         p4_A_ff   <= p3_A_ff;
         p4_et2_ff <= p3_et2_ff;
         p4_ei_ff  <= p3_ei_ff;
         p4_ent_ff <= p3_ent_ff;
      end
   end

   //------------------------------------------------------------------
   // Stage 5: decide total internal reflection exactly; radicand for
   // et*cos_t.
   //------------------------------------------------------------------
   fdr_rad_type p5_n_ff;
   logic        p5_tir_ff, p5_ent_ff;
   logic [30:0] p5_A_ff;
   logic [31:0] p5_et2_ff;
   logic [15:0] p5_ei_ff;

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p5_tir_ff <= p4_lhs_ff >= {1'b0, p4_rhs_ff};
         p5_n_ff   <= RAD_W'({1'b0, p4_rhs_ff} - p4_lhs_ff);
         p5_A_ff   <= p4_A_ff;
         p5_et2_ff <= p4_et2_ff;
         p5_ei_ff  <= p4_ei_ff;
         p5_ent_ff <= p4_ent_ff;
      end
   end

   //------------------------------------------------------------------
   // Root pipeline; carry the sideband alongside it.
   //------------------------------------------------------------------
   fdr_root_type sq_root;
   logic         sq_tir_ff [SQRT_STAGES];
   logic         sq_ent_ff [SQRT_STAGES];
   logic [30:0]  sq_A_ff   [SQRT_STAGES];
   logic [31:0]  sq_et2_ff [SQRT_STAGES];
   logic [15:0]  sq_ei_ff  [SQRT_STAGES];

   fdr_sqrt u_sqrt (
      .clock    (clock),
      .advance  (pipe_advance),
      .radicand (p5_n_ff),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         sq_tir_ff[0] <= p5_tir_ff;
         sq_ent_ff[0] <= p5_ent_ff;
         sq_A_ff[0]   <= p5_A_ff;
         sq_et2_ff[0] <= p5_et2_ff;
         sq_ei_ff[0]  <= p5_ei_ff;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            sq_tir_ff[i] <= sq_tir_ff[i-1];
            sq_ent_ff[i] <= sq_ent_ff[i-1];
            sq_A_ff[i]   <= sq_A_ff[i-1];
            sq_et2_ff[i] <= sq_et2_ff[i-1];
            sq_ei_ff[i]  <= sq_ei_ff[i-1];
         end
      end
   end

   //------------------------------------------------------------------
   // Stage 6: products for the two amplitude ratios.
   //------------------------------------------------------------------
   logic [62:0]  p6_xpar_ff;
   logic [46:0]  p6_eiq_ff, p6_xper_ff;
   fdr_root_type p6_q_ff;
   logic         p6_tir_ff, p6_ent_ff;

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p6_xpar_ff <= 63'(sq_et2_ff[SQRT_STAGES-1]) * 63'(sq_A_ff[SQRT_STAGES-1]);
         p6_eiq_ff  <= 47'(sq_ei_ff[SQRT_STAGES-1]) * 47'(sq_root);
         p6_xper_ff <= 47'(sq_ei_ff[SQRT_STAGES-1]) * 47'(sq_A_ff[SQRT_STAGES-1]);
         p6_q_ff    <= sq_root;
         p6_tir_ff  <= sq_tir_ff[SQRT_STAGES-1];
         p6_ent_ff  <= sq_ent_ff[SQRT_STAGES-1];
      end
   end

   //------------------------------------------------------------------
   // Stage 7: difference magnitude and sum of each ratio.
   //------------------------------------------------------------------
   logic [62:0] xpar, ypar, xper, yper;
   logic [62:0] p7_dpar_in, p7_dper_in;
   logic [62:0] p7_dpar_ff, p7_spar_ff, p7_dper_ff, p7_sper_ff;
   logic        p7_tir_ff, p7_ent_ff;

   always_comb begin
      xpar       = p6_xpar_ff;
      ypar       = {1'b0, p6_eiq_ff, 15'd0};
      xper       = {16'd0, p6_xper_ff};
      yper       = {17'd0, p6_q_ff, 15'd0};
      p7_dpar_in = (xpar >= ypar) ? xpar - ypar : ypar - xpar;
      p7_dper_in = (xper >= yper) ? xper - yper : yper - xper;
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p7_dpar_ff <= p7_dpar_in;
         p7_spar_ff <= xpar + ypar;
         p7_dper_ff <= p7_dper_in;
         p7_sper_ff <= xper + yper;
         p7_tir_ff  <= p6_tir_ff;
         p7_ent_ff  <= p6_ent_ff;
      end
   end

   //------------------------------------------------------------------
   // Stage 8: find the normalizing shift; flag a zero sum.
   //------------------------------------------------------------------
   logic [62:0] p8_dpar_ff, p8_spar_ff, p8_dper_ff, p8_sper_ff;
   logic [4:0]  p8_shpar_ff, p8_shper_ff;
   logic        p8_zpar_ff, p8_zper_ff, p8_tir_ff, p8_ent_ff;

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p8_dpar_ff  <= p7_dpar_ff;
         p8_spar_ff  <= p7_spar_ff;
         p8_dper_ff  <= p7_dper_ff;
         p8_sper_ff  <= p7_sper_ff;
         p8_shpar_ff <= norm_shift(p7_spar_ff);
         p8_shper_ff <= norm_shift(p7_sper_ff);
         p8_zpar_ff  <= p7_spar_ff == '0;
         p8_zper_ff  <= p7_sper_ff == '0;
         p8_tir_ff   <= p7_tir_ff;
         p8_ent_ff   <= p7_ent_ff;
      end
   end

   //------------------------------------------------------------------
   // Stage 9: shift difference and sum right together (truncating).
   //------------------------------------------------------------------
   fdr_quo_type p9_dpar_ff, p9_spar_ff, p9_dper_ff, p9_sper_ff;
   logic        p9_zpar_ff, p9_zper_ff, p9_tir_ff, p9_ent_ff;

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p9_dpar_ff <= QUO_W'(p8_dpar_ff >> p8_shpar_ff);
         p9_spar_ff <= QUO_W'(p8_spar_ff >> p8_shpar_ff);
         p9_dper_ff <= QUO_W'(p8_dper_ff >> p8_shper_ff);
         p9_sper_ff <= QUO_W'(p8_sper_ff >> p8_shper_ff);
         p9_zpar_ff <= p8_zpar_ff;
         p9_zper_ff <= p8_zper_ff;
         p9_tir_ff  <= p8_tir_ff;
         p9_ent_ff  <= p8_ent_ff;
      end
   end

   //------------------------------------------------------------------
   // Ratio dividers, one per polarization; carry the sideband.
   //------------------------------------------------------------------
   fdr_quo_type dv_qpar, dv_qper;
   logic        dv_zpar_ff [DIV_STAGES];
   logic        dv_zper_ff [DIV_STAGES];
   logic        dv_tir_ff  [DIV_STAGES];
   logic        dv_ent_ff  [DIV_STAGES];

   fdr_divider u_div_par (
      .clock    (clock),
      .advance  (pipe_advance),
      .dividend (p9_dpar_ff),
      .divisor  (p9_spar_ff),
      .quotient (dv_qpar)
   );

   fdr_divider u_div_per (
      .clock    (clock),
      .advance  (pipe_advance),
      .dividend (p9_dper_ff),
      .divisor  (p9_sper_ff),
      .quotient (dv_qper)
   );

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         dv_zpar_ff[0] <= p9_zpar_ff;
         dv_zper_ff[0] <= p9_zper_ff;
         dv_tir_ff[0]  <= p9_tir_ff;
         dv_ent_ff[0]  <= p9_ent_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            dv_zpar_ff[i] <= dv_zpar_ff[i-1];
            dv_zper_ff[i] <= dv_zper_ff[i-1];
            dv_tir_ff[i]  <= dv_tir_ff[i-1];
            dv_ent_ff[i]  <= dv_ent_ff[i-1];
         end
      end
   end

   //------------------------------------------------------------------
   // Stage 10: square each ratio. A zero sum counts as magnitude one.
   //------------------------------------------------------------------
   localparam fdr_quo_type RATIO_ONE = fdr_quo_type'(1) << (QUO_W - 1);

   fdr_quo_type rpar, rper;
   logic [63:0] p10_sqpar_ff, p10_sqper_ff;
   logic        p10_tir_ff, p10_ent_ff;

   assign rpar = dv_zpar_ff[DIV_STAGES-1] ? RATIO_ONE : dv_qpar;
   assign rper = dv_zper_ff[DIV_STAGES-1] ? RATIO_ONE : dv_qper;

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         p10_sqpar_ff <= 64'(rpar) * 64'(rpar);
         p10_sqper_ff <= 64'(rper) * 64'(rper);
         p10_tir_ff   <= dv_tir_ff[DIV_STAGES-1];
         p10_ent_ff   <= dv_ent_ff[DIV_STAGES-1];
      end
   end

   //------------------------------------------------------------------
   // Result register: average into Q0.16, saturate, force full
   // reflectance on total internal reflection.
   //------------------------------------------------------------------
   logic [63:0] refl_sum;
   logic [16:0] refl_wide;
   logic [15:0] refl_in;
   logic [15:0] rsp_reflectance_ff;
   logic        rsp_total_internal_ff, rsp_is_entering_ff;

   always_comb begin
      refl_sum  = p10_sqpar_ff + p10_sqper_ff;
      refl_wide = refl_sum[63:47];
      if (p10_tir_ff || refl_wide[16]) begin
         refl_in = 16'hFFFF;
      end else begin
         refl_in = refl_wide[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         rsp_reflectance_ff    <= refl_in;
         rsp_total_internal_ff <= p10_tir_ff;
         rsp_is_entering_ff    <= p10_ent_ff;
      end
   end

   assign rsp_reflectance    = rsp_reflectance_ff;
   assign rsp_total_internal = rsp_total_internal_ff;
   assign rsp_is_entering    = rsp_is_entering_ff;

endmodule

`default_nettype wire

### design/fdr_checker.sv
`default_nettype none

module fdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_reflectance,
   input logic        rsp_total_internal,
   input logic        rsp_is_entering
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reflectance)
         && $stable(rsp_total_internal) && $stable(rsp_is_entering))
      else $error("stalled result changed");

   // Full reflection always reports the saturated code.
   a_tir_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_internal |-> rsp_reflectance == 16'hFFFF)
      else $error("total internal reflection without full reflectance");

   // A stalled result stops intake.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while result stalled");

   // Reset empties the pipe.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (.*);

`default_nettype wire
